FILE: design/nesnap_pkg.sv
package nesnap_pkg;

    // coordinate and field widths
    localparam int COORD_W = 16;
    localparam int IDX_W   = 10;
    localparam int TOL_W   = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd160;

    // shared multiplier: 18x18 signed covers 17-bit deltas and t in 0..65536
    localparam int MUL_W  = 18;
    localparam int PROD_W = 36;

    // divider: dot and len2 fit 34 bits, quotient is a Q0.16 fraction
    localparam int LEN_W    = 34;
    localparam int Q_W      = 16;
    localparam int DIV_CNT_W = $clog2(Q_W);

    // t = 1.0 in Q1.16 and the rounding half
    localparam logic [Q_W:0]               T_ONE    = 17'h10000;
    localparam logic signed [PROD_W-1:0]   RND_HALF = 36'sd32768;

    // stream payload widths
    localparam int S_TDATA_W = 4 * COORD_W;
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - 2 * COORD_W - IDX_W;

    // op codes carried on s_tuser
    localparam logic OP_QUERY   = 1'b0;
    localparam logic OP_SEGMENT = 1'b1;

    // multiply/accumulate step counter
    localparam int STEP_W = 3;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PRE   = 7'b0000010,
        ST_CLAMP = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_POST  = 7'b0010000,
        ST_UPD   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: design/nearest_edge_point_snap.sv
// Nearest point on a stream of line segments, with a snap radius.
// Input stream (s_*): a request with s_tuser = 0 loads the cursor from
// x_start/y_start and clears the best match and edge counter; s_tuser = 1 is
// a segment. s_tlast on a segment queues one result for the query so far.
// Result stream (m_*): m_tuser = found, m_tdata = snap point and edge index.
// Config channel (cfg_*): writes the tolerance, always ready; write it only
// while the block is idle. Reset loads tolerance 160 and clears the sequencer,
// cursor, best match, edge counter and m_tvalid, but not the datapath registers.
// A segment holds s_tready low while one shared 18x18 multiplier runs through
// its products and a 1-bit-per-cycle divider forms t. The 16-step divide runs
// only when t lies strictly between 0 and 1; a zero-length segment skips it and
// the distance products; a segment with tlast then loads the output register.
// The output register decouples the sides: a stalled m_tready only blocks
// the block when a second result is ready before the first was taken.
module nearest_edge_point_snap #(
    parameter int MAX_EDGES = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // tolerance register write
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nesnap_pkg::TOL_W-1:0]         cfg_data,
    // input requests
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [15:0] x_start, [31:16] y_start, [47:32] x_end, [63:48] y_end
    input  logic [nesnap_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] op
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    // results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [15:0] snap_x, [31:16] snap_y, [41:32] edge_index, [47:42] zero
    output logic [nesnap_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] found
    output logic                                 m_tuser
);
    import nesnap_pkg::*;

    localparam int CNT_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EDGES - 1);
    // signed zero so dot compares stay signed
    localparam logic signed [PROD_W-1:0] DOT_ZERO = '0;

    state_t state_reg;
    logic [STEP_W-1:0] step_reg;

    // configuration
    logic [TOL_W-1:0] tol_reg;

    // query state
    logic signed [COORD_W-1:0] cursor_x_reg, cursor_y_reg;
    logic                      best_valid_reg;
    logic signed [PROD_W-1:0]  best_d2_reg;
    logic signed [COORD_W-1:0] best_x_reg, best_y_reg;
    logic [CNT_W-1:0]          best_index_reg;
    logic [CNT_W-1:0]          edge_count_reg;

    // current segment
    logic signed [COORD_W-1:0] xs_reg, ys_reg;
    logic signed [COORD_W:0]   dx_reg, dy_reg;
    logic                      last_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic                      cand_reg;
    logic signed [PROD_W-1:0]  len2_reg, dot_reg, tol2_reg, d2_reg;
    logic [Q_W:0]              t_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;

    // result register
    logic                      m_tvalid_reg;
    logic                      out_found_reg;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg;
    logic [IDX_W-1:0]          out_idx_reg;

    // input unpack
    logic signed [COORD_W-1:0] in_xs, in_ys, in_xe, in_ye;
    assign in_xs = s_tdata[COORD_W-1:0];
    assign in_ys = s_tdata[2*COORD_W-1:COORD_W];
    assign in_xe = s_tdata[3*COORD_W-1:2*COORD_W];
    assign in_ye = s_tdata[4*COORD_W-1:3*COORD_W];

    logic s_fire;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // shared multiplier operands
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [COORD_W:0]  ax, ay, ex, ey;

    assign ax = (COORD_W+1)'(cursor_x_reg) - (COORD_W+1)'(xs_reg);
    assign ay = (COORD_W+1)'(cursor_y_reg) - (COORD_W+1)'(ys_reg);
    assign ex = (COORD_W+1)'(cursor_x_reg) - (COORD_W+1)'(px_reg);
    assign ey = (COORD_W+1)'(cursor_y_reg) - (COORD_W+1)'(py_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_PRE) begin
            unique case (step_reg)
                3'd0: begin mul_a = MUL_W'(dx_reg); mul_b = MUL_W'(dx_reg); end
                3'd1: begin mul_a = MUL_W'(dy_reg); mul_b = MUL_W'(dy_reg); end
                3'd2: begin mul_a = MUL_W'(ax);     mul_b = MUL_W'(dx_reg); end
                3'd3: begin mul_a = MUL_W'(ay);     mul_b = MUL_W'(dy_reg); end
                3'd4: begin mul_a = MUL_W'(tol_reg); mul_b = MUL_W'(tol_reg); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (state_reg == ST_POST) begin
            unique case (step_reg)
                3'd0: begin mul_a = MUL_W'(t_reg); mul_b = MUL_W'(dx_reg); end
                3'd1: begin mul_a = MUL_W'(t_reg); mul_b = MUL_W'(dy_reg); end
                3'd2: begin mul_a = MUL_W'(ex);    mul_b = MUL_W'(ex);     end
                3'd3: begin mul_a = MUL_W'(ey);    mul_b = MUL_W'(ey);     end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    nesnap_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // round-to-nearest of t*d / 65536, ties up; result taken mod 2^16
    logic signed [PROD_W-1:0]  rnd_sum;
    logic signed [COORD_W-1:0] rnd_val;
    assign rnd_sum = prod + RND_HALF;
    assign rnd_val = rnd_sum[Q_W+COORD_W-1:Q_W];

    // divider
    logic      div_start;
    div_stat_t div_stat;
    logic [Q_W-1:0] div_quot;

    assign div_start = (state_reg == ST_CLAMP) && (len2_reg != '0) &&
                       (dot_reg > DOT_ZERO) && (dot_reg < len2_reg);

    nesnap_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dot_reg[LEN_W-1:0]),
        .divisor  (len2_reg[LEN_W-1:0]),
        .stat     (div_stat),
        .quot     (div_quot)
    );

    logic better;
    assign better = cand_reg && (d2_reg < tol2_reg) &&
                    (!best_valid_reg || (d2_reg < best_d2_reg));

    logic emit_load;
    assign emit_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            tol_reg        <= TOL_RESET;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            best_valid_reg <= 1'b0;
            best_d2_reg    <= '0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            best_index_reg <= '0;
            edge_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                tol_reg <= cfg_data;
            end

            if (emit_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_tuser == OP_QUERY) begin
                            cursor_x_reg   <= in_xs;
                            cursor_y_reg   <= in_ys;
                            best_valid_reg <= 1'b0;
                            best_d2_reg    <= '0;
                            best_x_reg     <= '0;
                            best_y_reg     <= '0;
                            best_index_reg <= '0;
                            edge_count_reg <= '0;
                        end else begin
                            if (edge_count_reg < CNT_MAX) begin
                                edge_count_reg <= edge_count_reg + 1'b1;
                            end
                            step_reg  <= '0;
                            state_reg <= ST_PRE;
                        end
                    end
                end
                ST_PRE: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd5) begin
                        state_reg <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    step_reg <= '0;
                    if (len2_reg == '0) begin
                        state_reg <= ST_UPD;
                    end else if (div_start) begin
                        state_reg <= ST_DIV;
                    end else begin
                        state_reg <= ST_POST;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd4) begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (better) begin
                        best_valid_reg <= 1'b1;
                        best_d2_reg    <= d2_reg;
                        best_x_reg     <= px_reg;
                        best_y_reg     <= py_reg;
                        best_index_reg <= idx_reg;
                    end
                    state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_fire) begin
            xs_reg   <= in_xs;
            ys_reg   <= in_ys;
            dx_reg   <= (COORD_W+1)'(in_xe) - (COORD_W+1)'(in_xs);
            dy_reg   <= (COORD_W+1)'(in_ye) - (COORD_W+1)'(in_ys);
            last_reg <= s_tlast;
            idx_reg  <= edge_count_reg;
        end

        if (state_reg == ST_PRE) begin
            unique case (step_reg)
                3'd1:    len2_reg <= prod;
                3'd2:    len2_reg <= len2_reg + prod;
                3'd3:    dot_reg  <= prod;
                3'd4:    dot_reg  <= dot_reg + prod;
                3'd5:    tol2_reg <= prod;
                default: ;
            endcase
        end

        if (state_reg == ST_CLAMP) begin
            cand_reg <= (len2_reg != '0);
            if (dot_reg <= DOT_ZERO) begin
                t_reg <= '0;
            end else if (dot_reg >= len2_reg) begin
                t_reg <= T_ONE;
            end
        end

        if (state_reg == ST_DIV && div_stat.done) begin
            t_reg <= {1'b0, div_quot};
        end

        if (state_reg == ST_POST) begin
            unique case (step_reg)
                3'd1:    px_reg <= xs_reg + rnd_val;
                3'd2:    py_reg <= ys_reg + rnd_val;
                3'd3:    d2_reg <= prod;
                3'd4:    d2_reg <= d2_reg + prod;
                default: ;
            endcase
        end

        if (emit_load) begin
            out_found_reg <= best_valid_reg;
            out_x_reg     <= best_valid_reg ? best_x_reg : '0;
            out_y_reg     <= best_valid_reg ? best_y_reg : '0;
            out_idx_reg   <= best_valid_reg ? IDX_W'(best_index_reg) : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_idx_reg, out_y_reg, out_x_reg};

`ifndef SYNTHESIS
    // a segment request blocks the input on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_tuser == OP_SEGMENT) |=> !s_tready)
        else $error("input not held off after segment request");

    // a query request drops any earlier match
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_tuser == OP_QUERY) |=> !best_valid_reg)
        else $error("best match survived a query request");

    // results only come out of the emit state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit");

    // divider is running or finishing whenever the sequencer waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");

    // edge counter saturates
    assert property (@(posedge aclk) disable iff (!aresetn)
        edge_count_reg <= CNT_MAX)
        else $error("edge counter overran");
`endif

endmodule

FILE: design/nesnap_mul.sv
module nesnap_mul (
    input  logic                                  aclk,
    input  logic signed [nesnap_pkg::MUL_W-1:0]   a,
    input  logic signed [nesnap_pkg::MUL_W-1:0]   b,
    output logic signed [nesnap_pkg::PROD_W-1:0]  prod
);
    import nesnap_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

FILE: design/nesnap_div.sv
module nesnap_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [nesnap_pkg::LEN_W-1:0]  dividend,
    input  logic [nesnap_pkg::LEN_W-1:0]  divisor,
    output nesnap_pkg::div_stat_t         stat,
    output logic [nesnap_pkg::Q_W-1:0]    quot
);
    import nesnap_pkg::*;

    // restoring division, one quotient bit per cycle; dividend < divisor
    logic [LEN_W-1:0]     rem_reg;
    logic [LEN_W-1:0]     dvs_reg;
    logic [Q_W-1:0]       quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [LEN_W:0]       rem_sh;
    logic                 take;

    assign rem_sh = {rem_reg, 1'b0};
    assign take   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(Q_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= dividend;
            dvs_reg  <= divisor;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= take ? LEN_W'(rem_sh - {1'b0, dvs_reg}) : LEN_W'(rem_sh);
            quot_reg <= {quot_reg[Q_W-2:0], take};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

FILE: tb/sv/nesnap_checker.sv
`timescale 1ns / 1ps

module nesnap_checker
    import nesnap_pkg::*;
#(
    parameter int MAX_EDGES = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [TOL_W-1:0]       cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // [15:0] x_start, [31:16] y_start, [47:32] x_end, [63:48] y_end
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // [0] op
    input  logic                   s_tuser,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] snap_x, [31:16] snap_y, [41:32] edge_index, [47:42] zero
    input  logic [M_TDATA_W-1:0]   m_tdata,
    // [0] found
    input  logic                   m_tuser,
    output int                     mismatches,
    output int                     pending_results
);

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [IDX_W-1:0]   idx;
    } snap_t;

    logic [TOL_W-1:0] tol;
    longint           cur_x, cur_y;
    logic             best_ok;
    longint           best_d2, best_x, best_y;
    logic [IDX_W-1:0] best_idx, edge_cnt;
    snap_t            due_snaps[$];

    task automatic clear_best();
        best_ok  = 1'b0;
        best_d2  = 0;
        best_x   = 0;
        best_y   = 0;
        best_idx = '0;
        edge_cnt = '0;
    endtask

    // track one accepted request, queue the snap result a tlast segment produces
    task automatic snap_request(input logic op, input logic [S_TDATA_W-1:0] d,
                                input logic last);
        longint           sx, sy, dx, dy, len2, dot, t, px, py, ox, oy, d2, tol2;
        logic [IDX_W-1:0] idx;
        snap_t            r;
        sx = $signed(d[COORD_W-1:0]);
        sy = $signed(d[2*COORD_W-1:COORD_W]);
        dx = longint'($signed(d[3*COORD_W-1:2*COORD_W])) - sx;
        dy = longint'($signed(d[4*COORD_W-1:3*COORD_W])) - sy;
        if (op == OP_QUERY) begin
            cur_x = sx;
            cur_y = sy;
            clear_best();
        end else begin
            idx = edge_cnt;
            if (edge_cnt < MAX_EDGES - 1)
                edge_cnt++;
            len2 = dx * dx + dy * dy;
            // zero-length segment only burns an edge number
            if (len2 > 0) begin
                dot = (cur_x - sx) * dx + (cur_y - sy) * dy;
                if (dot <= 0)
                    t = 0;
                else if (dot >= len2)
                    t = 65536;
                else
                    t = (dot <<< 16) / len2;
                // round to nearest, ties up; >>> on longint floors
                px = sx + ((t * dx + 32768) >>> 16);
                py = sy + ((t * dy + 32768) >>> 16);
                ox = cur_x - px;
                oy = cur_y - py;
                d2 = ox * ox + oy * oy;
                tol2 = longint'(tol) * longint'(tol);
                if (d2 < tol2 && (!best_ok || d2 < best_d2)) begin
                    best_ok  = 1'b1;
                    best_d2  = d2;
                    best_x   = px;
                    best_y   = py;
                    best_idx = idx;
                end
            end
            if (last) begin
                r.found = best_ok;
                r.x     = best_ok ? best_x[COORD_W-1:0] : '0;
                r.y     = best_ok ? best_y[COORD_W-1:0] : '0;
                r.idx   = best_ok ? best_idx : '0;
                due_snaps = {due_snaps, r};
            end
        end
    endtask

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        snap_t want;
        if (due_snaps.size() == 0) begin
            $display("%0t ns: result with none expected, got found=%0d tdata=%h",
                     $time, m_tuser, m_tdata);
            mismatches++;
        end else begin
            want = due_snaps.pop_front();
            check_field("found", want.found, m_tuser);
            check_field("snap_x", $signed(want.x), $signed(m_tdata[COORD_W-1:0]));
            check_field("snap_y", $signed(want.y), $signed(m_tdata[2*COORD_W-1:COORD_W]));
            check_field("edge_index", want.idx, m_tdata[2*COORD_W+IDX_W-1:2*COORD_W]);
            check_field("pad", 0, m_tdata[M_TDATA_W-1:2*COORD_W+IDX_W]);
        end
    endtask

    // result first: it can never stem from a request accepted at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            tol   = TOL_RESET;
            cur_x = 0;
            cur_y = 0;
            clear_best();
            due_snaps.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                tol = cfg_data;
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                snap_request(s_tuser, s_tdata, s_tlast);
        end
        pending_results = due_snaps.size();
    end

endmodule

FILE: tb/sv/tb_nearest_edge_point_snap.sv
`timescale 1ns / 1ps

module tb_nearest_edge_point_snap;
    import nesnap_pkg::*;

    localparam int MAX_EDGES      = 1024;
    // covers the longest segment, divide included, and the load of the output register
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 600;
    // covers the long receiver hold plus a stalled segment, several times over
    localparam int WATCHDOG_LIMIT = 5000;
    // enough segments in one query to run the edge counter into saturation
    localparam int SAT_SEGMENTS   = 1040;
    localparam int CHUNK_ITEMS    = 45;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TOL_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int mismatches;
    int pending_results;

    // idling knobs, percent of cycles
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    // long receiver hold: stimulus bumps hold_ask, the receiver acknowledges
    int hold_ask     = 0;
    int hold_seen    = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;

    // cursor as last loaded by a query request (reset cursor is the origin)
    logic signed [COORD_W-1:0] cur_x = '0;
    logic signed [COORD_W-1:0] cur_y = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    nearest_edge_point_snap #(
        .MAX_EDGES (MAX_EDGES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    nesnap_checker #(
        .MAX_EDGES (MAX_EDGES)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    // Receiver: random stalls per rx_stall_pct, or one long hold on request.
    // The hold is counted here so the sender keeps pushing while results back up.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_seen != hold_ask) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_seen++;
            end else begin
                m_tready = ($urandom_range(1, 100) > rx_stall_pct);
            end
        end
    end

    // Watchdog: ends the run if no channel moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one request and hold it until taken. Valid stays high on return
    // so back-to-back requests keep it up at tx_idle_pct 0; callers that pause lower it.
    task automatic send_req(input logic op,
                            input logic signed [COORD_W-1:0] xs, ys, xe, ye,
                            input logic last);
        @(negedge aclk);
        while ($urandom_range(1, 100) <= tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {ye, xe, ys, xs};
        s_tuser  = op;
        s_tlast  = last;
        if (op == OP_QUERY) begin
            cur_x = xs;
            cur_y = ys;
        end
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Tolerance write: only with nothing in flight. After the last result a
    // segment without tlast may still be busy, so give it the drain time.
    task automatic set_tolerance(input logic [TOL_W-1:0] value);
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // full-scale coordinate, with the two extremes weighted up
    function automatic logic signed [COORD_W-1:0] pick_coord();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return {1'b1, {(COORD_W-1){1'b0}}};
        if (roll == 1)
            return {1'b0, {(COORD_W-1){1'b1}}};
        return COORD_W'($urandom());
    endfunction

    // coordinate within +-span of c, clipped to the Q12.4 range
    function automatic logic signed [COORD_W-1:0] jitter(input logic signed [COORD_W-1:0] c,
                                                         input int span);
        longint v;
        v = c;
        v = v + longint'($urandom_range(0, 2 * span)) - span;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[COORD_W-1:0];
    endfunction

    function automatic int near_span();
        case ($urandom_range(0, 3))
            0:       return 8;
            1:       return 100;
            2:       return 1000;
            default: return 20000;
        endcase
    endfunction

    // One query: optional cursor load, then nseg segments, tlast on the final
    // one unless the sequence is deliberately broken. Most segments sit near
    // the cursor so matches, clamping and ties all get exercised.
    task automatic run_query(input int nseg, input bit with_query, input bit sat,
                             input bit drop_last);
        int                        k, roll, span;
        logic signed [COORD_W-1:0] ax, ay, bx, by;
        logic                      lst;
        ax = '0;
        ay = '0;
        bx = '0;
        by = '0;
        if (with_query)
            send_req(OP_QUERY, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                     1'($urandom_range(0, 1)));
        for (k = 0; k < nseg; k++) begin
            roll = $urandom_range(0, 99);
            // saturating query: cheap far/zero-length filler, near segments at the tail
            if (sat)
                roll = (k < nseg - 12) ? ($urandom_range(0, 1) ? 75 : 90) : 0;
            if (roll < 50) begin
                span = near_span();
                ax = jitter(cur_x, span);
                ay = jitter(cur_y, span);
                bx = jitter(cur_x, near_span());
                by = jitter(cur_y, near_span());
            end else if (roll < 60) begin
                // same segment again: equal distance, earlier edge keeps the match
            end else if (roll < 70) begin
                {ax, ay, bx, by} = {bx, by, ax, ay};
            end else if (roll < 78) begin
                ax = pick_coord();
                ay = pick_coord();
                bx = ax;
                by = ay;
            end else begin
                ax = pick_coord();
                ay = pick_coord();
                bx = pick_coord();
                by = pick_coord();
            end
            lst = (k == nseg - 1) && !drop_last;
            send_req(OP_SEGMENT, ax, ay, bx, by, lst);
        end
    endtask

    initial begin
        int               ph, c, start, nseg;
        logic [TOL_W-1:0] tol_pick;

        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_QUERY;
        s_tlast   = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ---- directed, reset tolerance ----
        // segment before any query: cursor is the origin
        send_req(OP_SEGMENT, -100, 50, 100, 50, 1'b1);
        // tlast on a query request is ignored
        send_req(OP_QUERY, 10, 20, 0, 0, 1'b1);
        send_req(OP_SEGMENT, 5, 5, 5, 5, 1'b0);         // zero length, edge 0
        send_req(OP_SEGMENT, 30, 20, 100, 20, 1'b0);    // t clamps to 0
        send_req(OP_SEGMENT, -100, 20, 0, 20, 1'b0);    // t clamps to 1
        send_req(OP_SEGMENT, -100, 20, 0, 20, 1'b1);    // tie, edge 2 stays
        send_req(OP_SEGMENT, 10, 25, 20, 25, 1'b1);     // query goes on after result
        // coordinate extremes
        send_req(OP_QUERY, -32768, -32768, 0, 0, 1'b0);
        send_req(OP_SEGMENT, -32768, -32768, 32767, 32767, 1'b0);
        send_req(OP_SEGMENT, 32767, -32768, -32768, 32767, 1'b1);
        send_req(OP_QUERY, 32767, 32767, 0, 0, 1'b0);
        send_req(OP_SEGMENT, -32768, -32768, 32767, 32767, 1'b1);
        // interior t with rounding of the fraction
        send_req(OP_QUERY, 1, 1, 0, 0, 1'b0);
        send_req(OP_SEGMENT, 0, 0, 3, 0, 1'b0);
        send_req(OP_SEGMENT, 0, 3, 2, -1, 1'b1);
        // zero tolerance: a hit at distance 0 still does not count
        set_tolerance('0);
        send_req(OP_QUERY, 0, 0, 0, 0, 1'b0);
        send_req(OP_SEGMENT, -5, 0, 5, 0, 1'b1);
        // widest tolerance
        set_tolerance('1);
        send_req(OP_QUERY, -32768, 32767, 0, 0, 1'b0);
        send_req(OP_SEGMENT, 32767, -32768, 32767, -32767, 1'b1);
        send_req(OP_SEGMENT, 32767, 32767, -32768, -32768, 1'b1);

        // ---- random: four idling phases, tolerance changes per chunk ----
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 80;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 80;
                end
                default: begin
                    tx_idle_pct  = 13;
                    rx_stall_pct = 13;
                end
            endcase
            for (c = 0; c < 4; c++) begin
                case ((ph * 4 + c) % 6)
                    0:       tol_pick = '1;
                    1:       tol_pick = TOL_RESET;
                    2:       tol_pick = '0;
                    3:       tol_pick = TOL_W'($urandom_range(1, 3000));
                    4:       tol_pick = 16'd1;
                    default: tol_pick = TOL_W'($urandom());
                endcase
                // sender waits here for every outstanding result
                set_tolerance(tol_pick);
                start = items_sent;
                // long receiver hold while short queries keep arriving
                if (ph == 0 && c == 1)
                    hold_ask++;
                if (ph == 0 && c == 3)
                    run_query(SAT_SEGMENTS, 1'b1, 1'b1, 1'b0);
                while (items_sent - start < CHUNK_ITEMS) begin
                    nseg = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 6)
                                                       : $urandom_range(7, 30);
                    run_query(nseg, $urandom_range(0, 9) != 0, 1'b0,
                              $urandom_range(0, 19) == 0);
                end
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
